/* rtl/rmc_pkg.sv */
package rmc_pkg;

  // Joint index width and matrix capacity
  localparam int JOINT_W    = 5;
  localparam int MAX_JOINTS = 1 << JOINT_W;
  localparam int COUNT_W    = JOINT_W + 1;
  localparam int ADDR_W     = 2 * JOINT_W;
  localparam int RAM_DEPTH  = MAX_JOINTS * MAX_JOINTS;

  typedef logic [1:0]         kind_t;
  typedef logic [JOINT_W-1:0] joint_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  localparam kind_t KIND_CONSTRAINED   = 2'd0;
  localparam kind_t KIND_PARAMETERIZED = 2'd1;
  localparam kind_t KIND_UNCONSTRAINED = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Request to the relation unit: links of the spread path and the stored entry
  typedef struct packed {
    logic  par;
    kind_t link_a;
    kind_t link_b;
    kind_t cur;
  } alu_req_t;

  typedef struct packed {
    kind_t spread;
    logic  lowers;
  } alu_rsp_t;

  // Row-major address of one matrix entry
  function automatic addr_t pair_addr(joint_t row, joint_t col);
    return {row, col};
  endfunction

endpackage

/* rtl/rmc_ram.sv */
module rmc_ram
  import rmc_pkg::*;
(
  input  logic  clk,
  input  logic  wr_en,
  input  addr_t wr_addr,
  input  kind_t wr_data,
  input  logic  rd_en,
  input  addr_t rd_addr,
  output kind_t rd_data
);

  kind_t mem [RAM_DEPTH];
  kind_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/rmc_alu.sv */
module rmc_alu
  import rmc_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  kind_t spread;

  // Constrained only when every link is constrained and the added kind is too
  assign spread = (!req.par && req.link_a == KIND_CONSTRAINED &&
                   req.link_b == KIND_CONSTRAINED) ? KIND_CONSTRAINED
                                                   : KIND_PARAMETERIZED;

  assign rsp.spread = spread;
  assign rsp.lowers = (spread < req.cur);

endmodule

/* rtl/relative_motion_closure.sv */
// Channel   Handshake              Payload
// ------    ---------              -------
// request   start && !busy         in_command, in_first_joint, in_second_joint,
//                                  in_relation_kind
// result    out_valid (1 cycle)    out_entry_value, out_index_error
// config    cfg_valid && cfg_ready cfg_joint_count
//
// Every request gives exactly one result. A read is answered from S_READ, an invalid
// or out-of-range request straight from idle, a clear after its sweep (one entry a cycle).
// An add that lowers its pair walks all joint pairs: each visited pair is read
// from the relation memory and, where it lowers, written back with its mirror.
// After reset the block sweeps all 1024 entries (busy high) before taking a
// request; configuration writes are taken at any time. The receiver cannot
// stall the result.
module relative_motion_closure
  import rmc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   in_command,
  input  logic [4:0]   in_first_joint,
  input  logic [4:0]   in_second_joint,
  input  logic [1:0]   in_relation_kind,
  output logic         out_valid,
  output logic [1:0]   out_entry_value,
  output logic         out_index_error,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [5:0]   cfg_joint_count
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_LOWER,
    S_MIRROR,
    S_L1_Y,
    S_L1_B,
    S_L2_X,
    S_L2_A,
    S_L2_Y,
    S_L2_B
  } state_t;

  // Where the shared lowering routine resumes
  typedef enum logic [1:0] {
    RET_ADD,
    RET_L1,
    RET_L2X,
    RET_L2Y
  } ret_t;

  state_t   state_r, state_nxt;
  ret_t     ret_r, ret_nxt;
  joint_t   p_r, p_nxt;
  joint_t   q_r, q_nxt;
  logic     par_r, par_nxt;
  kind_t    kind_r, kind_nxt;
  count_t   x_r, x_nxt;
  count_t   y_r, y_nxt;
  kind_t    la_r, la_nxt;
  kind_t    lb_r, lb_nxt;
  joint_t   tgt_row_r, tgt_row_nxt;
  joint_t   tgt_col_r, tgt_col_nxt;
  addr_t    clr_cnt_r, clr_cnt_nxt;
  logic     clr_reply_r, clr_reply_nxt;
  logic     out_valid_r, out_valid_nxt;
  kind_t    out_entry_r, out_entry_nxt;
  logic     out_err_r, out_err_nxt;
  count_t   joint_count_r;

  count_t   n_act;
  kind_t    kind_in;
  logic     idx_err;
  logic     resume;
  joint_t   x5, y5;
  joint_t   clr_row, clr_col;

  logic     ram_wr_en, ram_rd_en;
  addr_t    ram_wr_addr, ram_rd_addr;
  kind_t    ram_wr_data, ram_rd_data;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  rmc_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  rmc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Configuration: single register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joint_count_r <= count_t'(MAX_JOINTS);
    end else if (cfg_valid && cfg_ready) begin
      joint_count_r <= cfg_joint_count;
    end
  end

  // Clamp the active side length to the capacity
  assign n_act = (joint_count_r > count_t'(MAX_JOINTS)) ? count_t'(MAX_JOINTS)
                                                        : joint_count_r;

  assign kind_in = (in_relation_kind > KIND_UNCONSTRAINED) ? KIND_UNCONSTRAINED
                                                           : in_relation_kind;
  assign idx_err = (count_t'(in_first_joint) >= n_act) ||
                   (count_t'(in_second_joint) >= n_act);

  assign x5      = x_r[JOINT_W-1:0];
  assign y5      = y_r[JOINT_W-1:0];
  assign clr_row = clr_cnt_r[ADDR_W-1:JOINT_W];
  assign clr_col = clr_cnt_r[JOINT_W-1:0];

  // The relation unit sees the path links held in registers and the entry
  // just read from memory
  assign alu_req = '{par: par_r, link_a: la_r, link_b: lb_r, cur: ram_rd_data};

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_entry_value = out_entry_r;
  assign out_index_error = out_err_r;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    par_nxt       = par_r;
    kind_nxt      = kind_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    la_nxt        = la_r;
    lb_nxt        = lb_r;
    tgt_row_nxt   = tgt_row_r;
    tgt_col_nxt   = tgt_col_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_reply_nxt = clr_reply_r;
    out_valid_nxt = 1'b0;
    out_entry_nxt = out_entry_r;
    out_err_nxt   = out_err_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = '0;
    ram_wr_data   = KIND_CONSTRAINED;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = '0;
    resume        = 1'b0;

    unique case (state_r)
      // Sweep the whole store back to the cleared pattern
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_cnt_r;
        ram_wr_data = (clr_row == clr_col) ? KIND_CONSTRAINED : KIND_UNCONSTRAINED;
        if (clr_cnt_r == addr_t'(RAM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
          if (clr_reply_r) begin
            out_valid_nxt = 1'b1;
            out_entry_nxt = KIND_UNCONSTRAINED;
            out_err_nxt   = 1'b0;
          end
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          p_nxt    = in_first_joint;
          q_nxt    = in_second_joint;
          kind_nxt = kind_in;
          par_nxt  = (kind_in == KIND_PARAMETERIZED);
          priority if (in_command == CMD_CLEAR) begin
            clr_cnt_nxt   = '0;
            clr_reply_nxt = 1'b1;
            state_nxt     = S_CLEAR;
          end else if (in_command == CMD_NONE) begin
            out_valid_nxt = 1'b1;
            out_entry_nxt = KIND_CONSTRAINED;
            out_err_nxt   = 1'b0;
          end else if (idx_err) begin
            out_valid_nxt = 1'b1;
            out_entry_nxt = KIND_CONSTRAINED;
            out_err_nxt   = 1'b1;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = pair_addr(in_first_joint, in_second_joint);
            la_nxt      = KIND_CONSTRAINED;
            lb_nxt      = KIND_CONSTRAINED;
            tgt_row_nxt = in_first_joint;
            tgt_col_nxt = in_second_joint;
            ret_nxt     = RET_ADD;
            // An unconstrained add can never lower anything: answer as a read
            if (in_command == CMD_ADD && kind_in != KIND_UNCONSTRAINED) begin
              state_nxt = S_LOWER;
            end else begin
              state_nxt = S_READ;
            end
          end
        end
      end

      S_READ: begin
        out_valid_nxt = 1'b1;
        out_entry_nxt = ram_rd_data;
        out_err_nxt   = 1'b0;
        state_nxt     = S_IDLE;
      end

      // Lower the target pair if the spread kind is below the stored entry
      S_LOWER: begin
        if (alu_rsp.lowers) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = pair_addr(tgt_row_r, tgt_col_r);
          ram_wr_data = alu_rsp.spread;
          state_nxt   = S_MIRROR;
        end else if (ret_r == RET_ADD) begin
          out_valid_nxt = 1'b1;
          out_entry_nxt = ram_rd_data;
          out_err_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          resume = 1'b1;
        end
      end

      // Keep the matrix symmetric
      S_MIRROR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = pair_addr(tgt_col_r, tgt_row_r);
        ram_wr_data = alu_rsp.spread;
        resume      = 1'b1;
      end

      // Spread over neighbours of the second joint onto the first
      S_L1_Y: begin
        if (y_r == n_act) begin
          x_nxt     = '0;
          state_nxt = S_L2_X;
        end else if (y5 == p_r || y5 == q_r) begin
          y_nxt = y_r + 1'b1;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = pair_addr(q_r, y5);
          state_nxt   = S_L1_B;
        end
      end

      S_L1_B: begin
        if (ram_rd_data == KIND_UNCONSTRAINED) begin
          y_nxt     = y_r + 1'b1;
          state_nxt = S_L1_Y;
        end else begin
          la_nxt      = KIND_CONSTRAINED;
          lb_nxt      = ram_rd_data;
          ram_rd_en   = 1'b1;
          ram_rd_addr = pair_addr(p_r, y5);
          tgt_row_nxt = p_r;
          tgt_col_nxt = y5;
          ret_nxt     = RET_L1;
          state_nxt   = S_LOWER;
        end
      end

      // Outer walk over neighbours of the first joint
      S_L2_X: begin
        if (x_r == n_act) begin
          out_valid_nxt = 1'b1;
          out_entry_nxt = kind_r;
          out_err_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end else if (x5 == p_r || x5 == q_r) begin
          x_nxt = x_r + 1'b1;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = pair_addr(x5, p_r);
          state_nxt   = S_L2_A;
        end
      end

      S_L2_A: begin
        if (ram_rd_data == KIND_UNCONSTRAINED) begin
          x_nxt     = x_r + 1'b1;
          state_nxt = S_L2_X;
        end else begin
          la_nxt      = ram_rd_data;
          lb_nxt      = KIND_CONSTRAINED;
          ram_rd_en   = 1'b1;
          ram_rd_addr = pair_addr(x5, q_r);
          tgt_row_nxt = x5;
          tgt_col_nxt = q_r;
          ret_nxt     = RET_L2X;
          state_nxt   = S_LOWER;
        end
      end

      // Inner walk: pairs that pass through both ends
      S_L2_Y: begin
        if (y_r == n_act) begin
          x_nxt     = x_r + 1'b1;
          state_nxt = S_L2_X;
        end else if (y5 == q_r || y5 == p_r || y5 == x5) begin
          y_nxt = y_r + 1'b1;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = pair_addr(q_r, y5);
          state_nxt   = S_L2_B;
        end
      end

      S_L2_B: begin
        if (ram_rd_data == KIND_UNCONSTRAINED) begin
          y_nxt     = y_r + 1'b1;
          state_nxt = S_L2_Y;
        end else begin
          lb_nxt      = ram_rd_data;
          ram_rd_en   = 1'b1;
          ram_rd_addr = pair_addr(x5, y5);
          tgt_row_nxt = x5;
          tgt_col_nxt = y5;
          ret_nxt     = RET_L2Y;
          state_nxt   = S_LOWER;
        end
      end
    endcase

    // Return from the lowering routine to the walk that called it
    if (resume) begin
      unique case (ret_r)
        RET_ADD: begin
          y_nxt     = '0;
          state_nxt = S_L1_Y;
        end
        RET_L1: begin
          y_nxt     = y_r + 1'b1;
          state_nxt = S_L1_Y;
        end
        RET_L2X: begin
          y_nxt     = '0;
          state_nxt = S_L2_Y;
        end
        RET_L2Y: begin
          y_nxt     = y_r + 1'b1;
          state_nxt = S_L2_Y;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
      ret_r       <= ret_nxt;
      p_r         <= p_nxt;
      q_r         <= q_nxt;
      par_r       <= par_nxt;
      kind_r      <= kind_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      la_r        <= la_nxt;
      lb_r        <= lb_nxt;
      tgt_row_r   <= tgt_row_nxt;
      tgt_col_r   <= tgt_col_nxt;
      out_entry_r <= out_entry_nxt;
      out_err_r   <= out_err_nxt;
    end
  end

endmodule

/* rtl/rmc_checker.sv */
module rmc_checker
  import rmc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_entry_value,
  input logic       out_index_error
);

  // An accepted request either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("request accepted but block neither busy nor answering");

  // A result only follows work in flight or a request just taken
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result strobe without a request");

  // Index errors are answered in the cycle after the request, with entry zero
  a_error_prompt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_index_error) |->
      ($past(start && !busy) && out_entry_value == KIND_CONSTRAINED))
    else $error("index error late or with non-zero entry");

  // Entries never take the unused code
  a_entry_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_value != 2'd3))
    else $error("result entry holds an unused code");

endmodule

bind relative_motion_closure rmc_checker u_rmc_checker (.*);
